>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock, off while in reset.
`define WSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent this cycle, consequent on the next clock edge.
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/wsd_pkg.sv
// Shared types and constants of the WebSocket deframer.
package wsd_pkg;

  // Width of the message size counter; the cap is clamped to 2^W - 1.
  localparam int unsigned MsgSizeW = 32;
  localparam logic [63:0] SizeLimit = (64'd1 << MsgSizeW) - 64'd1;

  localparam logic [31:0] CapReset = 32'd16777216;

  // Result kinds
  localparam logic [2:0] KIND_MSG_BYTE  = 3'd0;
  localparam logic [2:0] KIND_MSG_END   = 3'd1;
  localparam logic [2:0] KIND_PONG_BYTE = 3'd2;
  localparam logic [2:0] KIND_PONG_END  = 3'd3;
  localparam logic [2:0] KIND_CLOSE     = 3'd4;

  // Close status codes
  localparam logic [9:0] CLOSE_NORMAL   = 10'd1000;
  localparam logic [9:0] CLOSE_PROTOCOL = 10'd1002;
  localparam logic [9:0] CLOSE_TOO_BIG  = 10'd1009;

  // Frame opcodes
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // Result queue
  localparam int unsigned RqDepth = 4;
  localparam int unsigned RqAw    = $clog2(RqDepth);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       text;
    logic [9:0] code;
  } result_t;

  // Up to two results per input item; vld[1] only with vld[0].
  typedef struct packed {
    logic [1:0] vld;
    result_t    r0;
    result_t    r1;
  } step_t;

endpackage

>>> hw/rtl/wsd_parser.sv
// Frame parser: header, extended length, mask key, unmasking and message state.
module wsd_parser import wsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic [7:0]  in_byte_i,
  input  logic [31:0] cap_i,
  output step_t       step_o,
  output logic        closed_o
);

  localparam logic [2:0] PH_HEAD0   = 3'd0;
  localparam logic [2:0] PH_HEAD1   = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [2:0]  hcount_q, hcount_d;
  logic        fin_q, fin_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        rsv_q, rsv_d;
  logic        masked_q, masked_d;
  logic [63:0] flen_q, flen_d;
  logic [31:0] remain_q, remain_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  midx_q, midx_d;
  logic        rejected_q, rejected_d;
  logic        assembling_q, assembling_d;
  logic        text_q, text_d;
  logic [31:0] msize_q, msize_d;
  logic        closed_q, closed_d;

  logic        ld_go, fe_go, ld_masked;
  logic [63:0] ld_len, ext_len;
  logic [32:0] size_sum;
  logic [6:0]  len7;
  logic [7:0]  plain;
  logic [31:0] remain_dec;
  logic        pay_v, late_v;
  result_t     pay_r, late_r;

  assign len7       = in_byte_i[6:0];
  assign ext_len    = {flen_q[55:0], in_byte_i};
  assign plain      = in_byte_i ^ key_q[{~midx_q, 3'b000} +: 8];
  assign remain_dec = remain_q - 32'd1;
  assign size_sum   = {1'b0, msize_q} + {1'b0, ld_len[31:0]};

  always_comb begin
    phase_d      = phase_q;
    hcount_d     = hcount_q;
    fin_d        = fin_q;
    opcode_d     = opcode_q;
    rsv_d        = rsv_q;
    masked_d     = masked_q;
    flen_d       = flen_q;
    remain_d     = remain_q;
    key_d        = key_q;
    midx_d       = midx_q;
    rejected_d   = rejected_q;
    assembling_d = assembling_q;
    text_d       = text_q;
    msize_d      = msize_q;
    closed_d     = closed_q;
    ld_go        = 1'b0;
    ld_len       = 64'd0;
    ld_masked    = masked_q;
    fe_go        = 1'b0;
    pay_v        = 1'b0;
    pay_r        = '0;
    late_v       = 1'b0;
    late_r       = '0;

    if (fire_i && !closed_q) begin
      case (phase_q)
        PH_HEAD0: begin
          fin_d    = in_byte_i[7];
          rsv_d    = |in_byte_i[6:4];
          opcode_d = in_byte_i[3:0];
          phase_d  = PH_HEAD1;
        end
        PH_HEAD1: begin
          masked_d  = in_byte_i[7];
          ld_masked = in_byte_i[7];
          if (rsv_q || (opcode_q[3] && (!fin_q || len7 > 7'd125)) ||
              !(opcode_q inside {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG}))
          begin
            late_v   = 1'b1;
            late_r   = '{kind: KIND_CLOSE, data: 8'd0, text: 1'b0, code: CLOSE_PROTOCOL};
            closed_d = 1'b1;
          end else if (len7 == 7'd126) begin
            flen_d   = 64'd0;
            hcount_d = 3'd1;
            phase_d  = PH_EXTLEN;
          end else if (len7 == 7'd127) begin
            flen_d   = 64'd0;
            hcount_d = 3'd7;
            phase_d  = PH_EXTLEN;
          end else begin
            flen_d = {57'd0, len7};
            ld_go  = 1'b1;
            ld_len = {57'd0, len7};
          end
        end
        PH_EXTLEN: begin
          flen_d = ext_len;
          if (hcount_q == 3'd0) begin
            ld_go  = 1'b1;
            ld_len = ext_len;
          end else begin
            hcount_d = hcount_q - 3'd1;
          end
        end
        PH_MASK: begin
          key_d = {key_q[23:0], in_byte_i};
          if (hcount_q == 3'd0) begin
            midx_d = 2'd0;
            if (remain_q == 32'd0) fe_go = 1'b1;
            else phase_d = PH_PAYLOAD;
          end else begin
            hcount_d = hcount_q - 3'd1;
          end
        end
        PH_PAYLOAD: begin
          midx_d = midx_q + 2'd1;
          if (opcode_q[3]) begin
            if (opcode_q == OP_PING) begin
              pay_v = 1'b1;
              pay_r = '{kind: KIND_PONG_BYTE, data: plain, text: 1'b0, code: 10'd0};
            end
          end else if (!rejected_q) begin
            pay_v = 1'b1;
            pay_r = '{kind: KIND_MSG_BYTE, data: plain, text: text_q, code: 10'd0};
          end
          remain_d = remain_dec;
          if (remain_dec == 32'd0) fe_go = 1'b1;
        end
        default: phase_d = PH_HEAD0;
      endcase

      // Length complete: sanity, size cap, then message bookkeeping
      if (ld_go) begin
        if (ld_len[63] || !ld_masked) begin
          late_v   = 1'b1;
          late_r   = '{kind: KIND_CLOSE, data: 8'd0, text: 1'b0, code: CLOSE_PROTOCOL};
          closed_d = 1'b1;
        end else if ((|ld_len[62:32]) || ld_len[31:0] > cap_i || size_sum > {1'b0, cap_i})
        begin
          late_v   = 1'b1;
          late_r   = '{kind: KIND_CLOSE, data: 8'd0, text: 1'b0, code: CLOSE_TOO_BIG};
          closed_d = 1'b1;
        end else begin
          rejected_d = 1'b0;
          if (!opcode_q[3]) begin
            if (opcode_q == OP_CONT) begin
              if (!assembling_q) rejected_d = 1'b1;
              else msize_d = size_sum[31:0];
            end else if (assembling_q) begin
              rejected_d = 1'b1;
            end else begin
              assembling_d = 1'b1;
              text_d       = (opcode_q == OP_TEXT);
              msize_d      = ld_len[31:0];
            end
          end
          remain_d = ld_len[31:0];
          key_d    = 32'd0;
          hcount_d = 3'd3;
          phase_d  = PH_MASK;
        end
      end

      if (fe_go) begin
        phase_d = PH_HEAD0;
        if (opcode_q[3]) begin
          if (opcode_q == OP_CLOSE) begin
            late_v   = 1'b1;
            late_r   = '{kind: KIND_CLOSE, data: 8'd0, text: 1'b0, code: CLOSE_NORMAL};
            closed_d = 1'b1;
          end else if (opcode_q == OP_PING) begin
            late_v = 1'b1;
            late_r = '{kind: KIND_PONG_END, data: 8'd0, text: 1'b0, code: 10'd0};
          end
        end else if (rejected_q) begin
          rejected_d = 1'b0;
          late_v     = 1'b1;
          late_r     = '{kind: KIND_CLOSE, data: 8'd0, text: 1'b0, code: CLOSE_PROTOCOL};
          closed_d   = 1'b1;
        end else if (fin_q) begin
          late_v       = 1'b1;
          late_r       = '{kind: KIND_MSG_END, data: 8'd0, text: text_q, code: 10'd0};
          assembling_d = 1'b0;
          msize_d      = 32'd0;
        end
      end
    end
  end

  // Pack results so that the first slot is always filled first
  always_comb begin
    if (pay_v) begin
      step_o.vld = {late_v, 1'b1};
      step_o.r0  = pay_r;
      step_o.r1  = late_r;
    end else begin
      step_o.vld = {1'b0, late_v};
      step_o.r0  = late_r;
      step_o.r1  = '0;
    end
  end

  assign closed_o = closed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEAD0;
      hcount_q     <= 3'd0;
      fin_q        <= 1'b0;
      opcode_q     <= 4'd0;
      rsv_q        <= 1'b0;
      masked_q     <= 1'b0;
      flen_q       <= 64'd0;
      remain_q     <= 32'd0;
      key_q        <= 32'd0;
      midx_q       <= 2'd0;
      rejected_q   <= 1'b0;
      assembling_q <= 1'b0;
      text_q       <= 1'b0;
      msize_q      <= 32'd0;
      closed_q     <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      hcount_q     <= hcount_d;
      fin_q        <= fin_d;
      opcode_q     <= opcode_d;
      rsv_q        <= rsv_d;
      masked_q     <= masked_d;
      flen_q       <= flen_d;
      remain_q     <= remain_d;
      key_q        <= key_d;
      midx_q       <= midx_d;
      rejected_q   <= rejected_d;
      assembling_q <= assembling_d;
      text_q       <= text_d;
      msize_q      <= msize_d;
      closed_q     <= closed_d;
    end
  end

endmodule

>>> hw/rtl/wsd_result_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per cycle while out_ready_i is high.
module wsd_result_fifo import wsd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  step_t   step_i,
  output logic    room_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_r_o
);

  result_t mem_q [RqDepth];

  logic [RqAw-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [RqAw:0]   cnt_q, cnt_d;
  logic            pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_r_o     = mem_q[rptr_q];
  assign pop         = out_valid_o && out_ready_i;
  // Room for a full two-result item, judged before this cycle's pop
  assign room_o      = (cnt_q <= (RqAw+1)'(RqDepth - 2));

  assign wptr_d = wptr_q + RqAw'(step_i.vld[0]) + RqAw'(step_i.vld[1]);
  assign rptr_d = rptr_q + RqAw'(pop);
  assign cnt_d  = cnt_q + (RqAw+1)'(step_i.vld[0]) + (RqAw+1)'(step_i.vld[1])
                  - (RqAw+1)'(pop);

  always_ff @(posedge clk_i) begin
    if (step_i.vld[0]) mem_q[wptr_q] <= step_i.r0;
    if (step_i.vld[1]) mem_q[wptr_q + RqAw'(1)] <= step_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

>>> hw/rtl/websocket_client_frame_deframer.sv
// Top level of the WebSocket client-to-server frame deframer.
//
//   channel | direction | payload
//   in      | sink      | in_byte_i
//   out     | source    | kind_o, data_o, message_text_o, close_code_o
//   cfg     | sink      | cfg_data_i (max_message_bytes)
//
// One byte is taken every clock while in_ready_o is high; the parser updates its state
// in the same edge and writes zero, one or two results into a four-entry result queue.
// Results leave one per clock while out_ready_i is high, so in_ready_o drops when the
// queue holds more than two results; a stalled output fills it within a few items.
// Reset clears all parser state and the queue; no clearing pass is needed.
// After a close result, bytes are still taken but produce nothing.
`include "assert_macros.svh"

module websocket_client_frame_deframer import wsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  data_o,
  output logic        message_text_o,
  output logic [9:0]  close_code_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] max_bytes_q;
  logic [31:0] cap;
  logic        room, in_fire, closed;
  step_t       step;
  result_t     out_r;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = room;
  assign in_fire     = in_valid_i && in_ready_o;

  // Cap clamped to what the message size counter can hold
  assign cap = ({32'd0, max_bytes_q} > SizeLimit) ? SizeLimit[31:0] : max_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= CapReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_bytes_q <= cfg_data_i;
    end
  end

  wsd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (in_fire),
    .in_byte_i (in_byte_i),
    .cap_i     (cap),
    .step_o    (step),
    .closed_o  (closed)
  );

  wsd_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_r_o     (out_r)
  );

  assign kind_o         = out_r.kind;
  assign data_o         = out_r.data;
  assign message_text_o = out_r.text;
  assign close_code_o   = out_r.code;

  `WSD_ASSERT(a_step_packed, !step.vld[1] || step.vld[0], "second result without first")
  `WSD_ASSERT(a_step_needs_item, step.vld == 2'b00 || in_fire, "result without an item")
  `WSD_ASSERT(a_quiet_after_close, !closed || step.vld == 2'b00, "result after close")
  `WSD_ASSERT(a_stall_means_backlog, in_ready_o || out_valid_o, "input stalled on empty queue")
  `WSD_ASSERT_NEXT(a_close_latches, closed, closed, "close flag dropped")

endmodule

>>> tb/sv/tb_websocket_client_frame_deframer.sv
// Self-checking testbench for the WebSocket client frame deframer.
`timescale 1ns / 1ps

class ws_result_tracker;
  typedef enum logic [2:0] {ST_HEAD0, ST_HEAD1, ST_EXTLEN, ST_MASK, ST_PAYLOAD} stage_e;

  wsd_pkg::result_t due_results[$];

  logic [31:0] cap;
  stage_e      stage;
  int          hdr_cnt;
  bit          fin;
  logic [3:0]  opcode;
  bit          rsv;
  bit          masked;
  logic [63:0] flen;
  logic [31:0] remaining;
  logic [31:0] key;
  logic [1:0]  kidx;
  bit          rejected;
  bit          assembling;
  bit          is_text;
  logic [63:0] msg_size;
  bit          closed;

  int errors;
  int n_in;
  int n_out;
  int n_msgs;
  int n_pongs;
  int last_close;

  function new();
    cap        = wsd_pkg::CapReset;
    stage      = ST_HEAD0;
    hdr_cnt    = 0;
    fin        = 0;
    opcode     = '0;
    rsv        = 0;
    masked     = 0;
    flen       = '0;
    remaining  = '0;
    key        = '0;
    kidx       = '0;
    rejected   = 0;
    assembling = 0;
    is_text    = 0;
    msg_size   = '0;
    closed     = 0;
    errors     = 0;
    n_in       = 0;
    n_out      = 0;
    n_msgs     = 0;
    n_pongs    = 0;
    last_close = 0;
  endfunction

  function int pending();
    return due_results.size();
  endfunction

  task flag(string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function void push(logic [2:0] kind, logic [7:0] data, logic text, logic [9:0] code);
    wsd_pkg::result_t r;
    r.kind = kind;
    r.data = data;
    r.text = text;
    r.code = code;
    due_results.insert(due_results.size(), r);
  endfunction

  function void close_with(logic [9:0] code);
    closed = 1;
    push(wsd_pkg::KIND_CLOSE, 8'h00, 1'b0, code);
  endfunction

  function void end_of_frame();
    stage = ST_HEAD0;
    if (opcode[3]) begin
      if (opcode == wsd_pkg::OP_CLOSE) close_with(wsd_pkg::CLOSE_NORMAL);
      else if (opcode == wsd_pkg::OP_PING) push(wsd_pkg::KIND_PONG_END, 8'h00, 1'b0, 10'd0);
      return;
    end
    if (rejected) begin
      rejected = 0;
      close_with(wsd_pkg::CLOSE_PROTOCOL);
      return;
    end
    if (fin) begin
      push(wsd_pkg::KIND_MSG_END, 8'h00, is_text, 10'd0);
      assembling = 0;
      msg_size   = '0;
    end
  endfunction

  function void length_complete();
    logic [63:0] lim;
    logic [64:0] total;
    lim = {32'd0, cap};
    if (lim > wsd_pkg::SizeLimit) lim = wsd_pkg::SizeLimit;
    total = {1'b0, msg_size} + {1'b0, flen};
    if (flen[63] || !masked) begin
      close_with(wsd_pkg::CLOSE_PROTOCOL);
      return;
    end
    if (flen > lim || total > {1'b0, lim}) begin
      close_with(wsd_pkg::CLOSE_TOO_BIG);
      return;
    end
    rejected = 0;
    if (!opcode[3]) begin
      if (opcode == wsd_pkg::OP_CONT) begin
        if (!assembling) rejected = 1;
        else msg_size = msg_size + flen;
      end else if (assembling) begin
        rejected = 1;
      end else begin
        assembling = 1;
        is_text    = (opcode == wsd_pkg::OP_TEXT);
        msg_size   = flen;
      end
    end
    remaining = flen[31:0];
    key       = '0;
    hdr_cnt   = 3;
    stage     = ST_MASK;
  endfunction

  // One accepted byte: advance the parser copy and queue what it should produce.
  function void take_byte(logic [7:0] b);
    logic [6:0] l7;
    logic [7:0] d;
    int         sh;
    n_in++;
    if (closed) return;
    case (stage)
      ST_HEAD0: begin
        fin    = b[7];
        rsv    = |b[6:4];
        opcode = b[3:0];
        stage  = ST_HEAD1;
      end
      ST_HEAD1: begin
        l7     = b[6:0];
        masked = b[7];
        if (rsv) close_with(wsd_pkg::CLOSE_PROTOCOL);
        else if (opcode[3] && (!fin || l7 > 7'd125)) close_with(wsd_pkg::CLOSE_PROTOCOL);
        else if (!(opcode <= wsd_pkg::OP_BINARY || opcode == wsd_pkg::OP_CLOSE ||
                   opcode == wsd_pkg::OP_PING || opcode == wsd_pkg::OP_PONG))
          close_with(wsd_pkg::CLOSE_PROTOCOL);
        else begin
          flen = '0;
          if (l7 == 7'd126) begin
            hdr_cnt = 1;
            stage   = ST_EXTLEN;
          end else if (l7 == 7'd127) begin
            hdr_cnt = 7;
            stage   = ST_EXTLEN;
          end else begin
            flen = {57'd0, l7};
            length_complete();
          end
        end
      end
      ST_EXTLEN: begin
        flen = {flen[55:0], b};
        if (hdr_cnt == 0) length_complete();
        else hdr_cnt--;
      end
      ST_MASK: begin
        key = {key[23:0], b};
        if (hdr_cnt == 0) begin
          kidx = '0;
          if (remaining == 0) end_of_frame();
          else stage = ST_PAYLOAD;
        end else begin
          hdr_cnt--;
        end
      end
      ST_PAYLOAD: begin
        sh   = 3 - int'(kidx);
        d    = b ^ key[8*sh +: 8];
        kidx = kidx + 2'd1;
        if (opcode[3]) begin
          if (opcode == wsd_pkg::OP_PING) push(wsd_pkg::KIND_PONG_BYTE, d, 1'b0, 10'd0);
        end else if (!rejected) begin
          push(wsd_pkg::KIND_MSG_BYTE, d, is_text, 10'd0);
        end
        remaining = remaining - 32'd1;
        if (remaining == 0) end_of_frame();
      end
      default: stage = ST_HEAD0;
    endcase
  endfunction

  task match_result(logic [2:0] kind, logic [7:0] data, logic text, logic [9:0] code);
    wsd_pkg::result_t want;
    n_out++;
    if (due_results.size() == 0) begin
      flag($sformatf("unexpected result kind %0d data %02h text %0d code %0d",
                     kind, data, text, code));
      return;
    end
    want = due_results[0];
    due_results.delete(0);
    if (kind !== want.kind)
      flag($sformatf("result %0d kind %0d, wanted %0d", n_out, kind, want.kind));
    if (data !== want.data)
      flag($sformatf("result %0d data %02h, wanted %02h", n_out, data, want.data));
    if (text !== want.text)
      flag($sformatf("result %0d text %0d, wanted %0d", n_out, text, want.text));
    if (code !== want.code)
      flag($sformatf("result %0d close code %0d, wanted %0d", n_out, code, want.code));
    if (want.kind == wsd_pkg::KIND_MSG_END) n_msgs++;
    if (want.kind == wsd_pkg::KIND_PONG_END) n_pongs++;
    if (want.kind == wsd_pkg::KIND_CLOSE) last_close = int'(want.code);
  endtask
endclass

module tb_websocket_client_frame_deframer;
  import wsd_pkg::*;

  localparam int NumItems   = 1500;
  localparam int CfgSpacing = 240;
  localparam int Tail       = 16;
  // A correct run never goes this long without a handshake: the longest gaps
  // are the drain tail and a run of random idles, both far shorter.
  localparam int QuietLimit = 2000;

  typedef enum int {
    CL_RSV, CL_CTRL_FRAG, CL_CTRL_LONG, CL_BAD_OP, CL_LEN_MSB,
    CL_UNMASKED, CL_ORPHAN, CL_INTERLEAVE, CL_OVERSIZE, CL_CLOSE_FRAME
  } close_case_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  kind_o;
  logic [7:0]  data_o;
  logic        message_text_o;
  logic [9:0]  close_code_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = 32'd0;

  ws_result_tracker tracker;
  close_case_e      close_case;
  int               send_idle_pct = 0;
  int               stall_pct = 0;
  int               quiet = 0;
  int               n_cap_writes = 0;
  int               next_cfg;
  int               quarter_end;
  bit               moved;

  websocket_client_frame_deframer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .data_o        (data_o),
    .message_text_o(message_text_o),
    .close_code_o  (close_code_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Handshake monitor and stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = 0;
      if (in_valid_i && in_ready_o) begin
        tracker.take_byte(in_byte_i);
        moved = 1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        tracker.cap = cfg_data_i;
        n_cap_writes++;
        moved = 1;
      end
      if (out_valid_o && out_ready_i) begin
        tracker.match_result(kind_o, data_o, message_text_o, close_code_o);
        moved = 1;
      end
      if (moved) quiet = 0;
      else quiet++;
      if (quiet >= QuietLimit) begin
        $display("[%0t] timeout: no handshake for %0d cycles", $time, QuietLimit);
        $display("tb_websocket_client_frame_deframer: done, errors");
        $finish;
      end
    end
  end

  // Starts and ends at a falling edge; valid stays up until the caller's next drive.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Hold the sender until every queued result is out, then allow the tail.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (Tail) @(negedge clk_i);
  endtask

  task automatic write_cap(input logic [31:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_idling(input int m);
    case (m)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 63; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 63; end
      default: begin send_idle_pct = 11; stall_pct = 11; end
    endcase
  endtask

  function automatic logic [63:0] room_left();
    logic [63:0] c;
    c = {32'd0, tracker.cap};
    if (c > SizeLimit) c = SizeLimit;
    return (c > tracker.msg_size) ? c - tracker.msg_size : 64'd0;
  endfunction

  function automatic logic [31:0] pick_key();
    int unsigned p;
    p = $urandom_range(9);
    if (p == 0) return 32'h0000_0000;
    if (p == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // form 0: 7-bit length, 1: 16-bit extended, 2: 64-bit extended
  task automatic send_header(input bit fin, input logic [3:0] op, input logic [63:0] len,
                             input int form);
    send_byte({fin, 3'b000, op});
    case (form)
      0: send_byte({1'b1, len[6:0]});
      1: begin
        send_byte({1'b1, 7'd126});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({1'b1, 7'd127});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
  endtask

  task automatic send_frame(input bit fin, input logic [3:0] op, input int unsigned len,
                            input int form, input logic [31:0] key);
    send_header(fin, op, {32'd0, len}, form);
    for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    repeat (len) send_byte(8'($urandom_range(255)));
  endtask

  task automatic random_frame();
    logic [63:0] room;
    int unsigned len;
    int unsigned pick;
    int          form;
    bit          fin;
    logic [3:0]  op;
    room = room_left();
    pick = $urandom_range(99);
    fin  = 1;
    if (tracker.assembling) begin
      if (pick < 60) begin
        op  = OP_CONT;
        fin = ($urandom_range(99) < 30);
      end else if (pick < 85) op = OP_PING;
      else op = OP_PONG;
    end else begin
      if (pick < 70) begin
        op  = $urandom_range(1) ? OP_TEXT : OP_BINARY;
        fin = ($urandom_range(99) < 60);
      end else if (pick < 90) op = OP_PING;
      else op = OP_PONG;
    end
    if (op[3]) len = ($urandom_range(99) < 5) ? 125 : $urandom_range(12);
    else len = ($urandom_range(99) < 4) ? $urandom_range(126, 300) : $urandom_range(12);
    if (len > room) len = room[31:0];
    if (op[3]) form = 0;
    else if (len > 125) form = $urandom_range(1, 2);
    else begin
      pick = $urandom_range(99);
      form = (pick < 70) ? 0 : (pick < 85) ? 1 : 2;
    end
    send_frame(fin, op, len, form, pick_key());
  endtask

  function automatic logic [3:0] ctrl_op();
    case ($urandom_range(2))
      0: return OP_CLOSE;
      1: return OP_PING;
      default: return OP_PONG;
    endcase
  endfunction

  function automatic logic [3:0] good_op();
    case ($urandom_range(5))
      0: return OP_CONT;
      1: return OP_TEXT;
      2: return OP_BINARY;
      default: return ctrl_op();
    endcase
  endfunction

  task automatic directed();
    send_frame(1, OP_TEXT, 0, 0, 32'h0000_0000);
    send_frame(1, OP_BINARY, 1, 0, 32'hFFFF_FFFF);
    send_frame(1, OP_TEXT, 3, 1, pick_key());      // non-minimal 16-bit length
    send_frame(1, OP_BINARY, 2, 2, pick_key());    // non-minimal 64-bit length
    send_frame(1, OP_PING, 0, 0, 32'h0000_0000);
    send_frame(1, OP_PONG, 2, 0, pick_key());
    // fragmented text with control frames in between
    send_frame(0, OP_TEXT, 2, 0, pick_key());
    send_frame(1, OP_PING, 1, 0, pick_key());
    send_frame(0, OP_CONT, 1, 0, pick_key());
    send_frame(1, OP_PONG, 0, 0, pick_key());
    send_frame(1, OP_CONT, 2, 0, pick_key());
    send_frame(1, OP_PING, 125, 0, pick_key());
    send_frame(1, OP_BINARY, 130, 1, pick_key());
  endtask

  function automatic logic [31:0] cap_choice(input int k);
    case (k)
      0: return 32'hFFFF_FFFF;
      1: return 32'd0;
      2: return 32'd1;
      3: return CapReset;
      default: begin
        case ($urandom_range(3))
          0: return $urandom_range(64);
          1: return $urandom;
          2: return 32'hFFFF_FFFF;
          default: return 32'd0;
        endcase
      end
    endcase
  endfunction

  // Any close shuts the block for good, so exactly one close case ends the run.
  task automatic closing_frame();
    logic [63:0] room;
    logic [63:0] n64;
    logic [3:0]  op;
    int unsigned n;
    int          form;
    while (tracker.assembling) random_frame();
    close_case = close_case_e'($urandom_range(9));
    drain();
    if (close_case == CL_OVERSIZE) write_cap($urandom_range(20));
    // leave a partial message open so the close cuts it short
    if (close_case == CL_INTERLEAVE || (close_case != CL_ORPHAN && $urandom_range(1))) begin
      room = room_left();
      n    = $urandom_range(4);
      if (n > room) n = room[31:0];
      send_frame(0, $urandom_range(1) ? OP_TEXT : OP_BINARY, n, 0, pick_key());
    end
    room = room_left();
    op   = tracker.assembling ? OP_CONT : OP_BINARY;
    case (close_case)
      CL_RSV: begin
        send_byte({1'($urandom_range(1)), 3'($urandom_range(1, 7)), good_op()});
        send_byte(8'($urandom_range(255)));
      end
      CL_CTRL_FRAG: begin
        send_byte({4'b0000, ctrl_op()});
        send_byte({1'b1, 7'($urandom_range(125))});
      end
      CL_CTRL_LONG: begin
        send_byte({4'b1000, ctrl_op()});
        send_byte({1'($urandom_range(1)), 7'($urandom_range(126, 127))});
      end
      CL_BAD_OP: begin
        op = $urandom_range(1) ? 4'($urandom_range(3, 7)) : 4'($urandom_range(11, 15));
        send_byte({1'($urandom_range(1)), 3'b000, op});
        send_byte(8'($urandom_range(255)));
      end
      CL_LEN_MSB: begin
        send_byte({4'b1000, op});
        send_byte({1'b1, 7'd127});
        send_byte(8'($urandom_range(128, 255)));
        repeat (7) send_byte(8'($urandom_range(255)));
      end
      CL_UNMASKED: begin
        send_byte({4'b1000, op});
        send_byte({1'b0, 7'($urandom_range(125))});
      end
      CL_ORPHAN: begin
        n = $urandom_range(5);
        if (n > room) n = room[31:0];
        send_frame(1'($urandom_range(1)), OP_CONT, n, 0, pick_key());
      end
      CL_INTERLEAVE: begin
        n = $urandom_range(5);
        if (n > room) n = room[31:0];
        send_frame(1, $urandom_range(1) ? OP_TEXT : OP_BINARY, n, $urandom_range(2),
                   pick_key());
      end
      CL_OVERSIZE: begin
        if ($urandom_range(1)) begin
          n64  = room + 64'($urandom_range(1, 4));
          form = $urandom_range(2);
        end else begin
          n64  = {2'b01, 30'($urandom), 32'($urandom)};
          form = 2;
        end
        send_header(1, op, n64, form);
      end
      default: begin
        n = $urandom_range(6);
        if (n > room) n = room[31:0];
        send_frame(1, OP_CLOSE, n, 0, pick_key());
      end
    endcase
    // everything after the close must be swallowed silently
    repeat (30) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    tracker = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed();
    next_cfg = tracker.n_in + CfgSpacing / 2;
    for (int m = 0; m < 4; m++) begin
      drain();
      set_idling(m);
      quarter_end = tracker.n_in + NumItems / 4;
      while (tracker.n_in < quarter_end) begin
        if (tracker.n_in >= next_cfg && !tracker.assembling) begin
          drain();
          write_cap(cap_choice(n_cap_writes));
          next_cfg = tracker.n_in + CfgSpacing;
        end
        random_frame();
      end
    end
    closing_frame();
    drain();

    $display("tb: %0d bytes in, %0d results checked, %0d messages and %0d pongs completed",
             tracker.n_in, tracker.n_out, tracker.n_msgs, tracker.n_pongs);
    $display("tb: %0d cap settings, run ended by %s with close code %0d",
             n_cap_writes, close_case.name(), tracker.last_close);
    if (tracker.errors == 0) begin
      $display("tb_websocket_client_frame_deframer: done, clean");
    end else begin
      $display("tb_websocket_client_frame_deframer: done, errors");
    end
    $finish;
  end

endmodule
